FILE: hw/rtl/dgadsr_pkg.sv
package dgadsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LOG_DEPTH_DEF = 64;
    localparam int ENV_W_DEF     = FRAC_BITS_DEF + 2;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_KEEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_KEEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_KEEP  = 3'd5;

    localparam logic [CFG_W-1:0] ATTACK_RATE_RST   = 16'd655;
    localparam logic [CFG_W-1:0] ATTACK_KEEP_RST   = 16'd64880;
    localparam logic [CFG_W-1:0] DECAY_RATE_RST    = 16'd655;
    localparam logic [CFG_W-1:0] SUSTAIN_LEVEL_RST = 16'd32768;
    localparam logic [CFG_W-1:0] DECAY_KEEP_RST    = 16'd64880;
    localparam logic [CFG_W-1:0] RELEASE_KEEP_RST  = 16'd64880;

    localparam logic [63:0] DEB_IN_W   = 64'd655;
    localparam logic [15:0] DEB_KEEP_W = 16'd64881;
    localparam logic [15:0] DEB_HALF   = 16'd32768;
    localparam logic [63:0] LN2_Q32    = 64'd2977044472;
    localparam int          SERIES_TERMS = 30;

    typedef logic [1:0] stage_t;
    localparam stage_t STAGE_ATTACK  = 2'd0;
    localparam stage_t STAGE_DECAY   = 2'd1;
    localparam stage_t STAGE_RELEASE = 2'd2;

    typedef logic [3:0] step_t;
    localparam step_t S_EMIT = 4'd0;
    localparam step_t S_IDLE = 4'd1;
    localparam step_t S_DEB  = 4'd2;
    localparam step_t S_DEBW = 4'd3;
    localparam step_t S_ATK  = 4'd4;
    localparam step_t S_ATKW = 4'd5;
    localparam step_t S_CHK  = 4'd6;
    localparam step_t S_LOG1 = 4'd7;
    localparam step_t S_LOG2 = 4'd8;
    localparam step_t S_LOG3 = 4'd9;
    localparam step_t S_LOG4 = 4'd10;
    localparam step_t S_DCHK = 4'd11;
    localparam step_t S_DEC1 = 4'd12;
    localparam step_t S_DEC2 = 4'd13;
    localparam step_t S_REL  = 4'd14;
    localparam step_t S_RELW = 4'd15;

    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE   = 3'd0;
    localparam mul_sel_t MUL_DEB    = 3'd1;
    localparam mul_sel_t MUL_ATK    = 3'd2;
    localparam mul_sel_t MUL_LOGPOS = 3'd3;
    localparam mul_sel_t MUL_INTERP = 3'd4;
    localparam mul_sel_t MUL_TGT    = 3'd5;
    localparam mul_sel_t MUL_DEC    = 3'd6;
    localparam mul_sel_t MUL_REL    = 3'd7;

    typedef logic [3:0] op_t;
    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_LATCH   = 4'd1;
    localparam op_t OP_DEB_WR  = 4'd2;
    localparam op_t OP_ATK_WR  = 4'd3;
    localparam op_t OP_ROM_IDX = 4'd4;
    localparam op_t OP_ROM_LO  = 4'd5;
    localparam op_t OP_LOG_WR  = 4'd6;
    localparam op_t OP_TGT     = 4'd7;
    localparam op_t OP_DEC_WR  = 4'd8;
    localparam op_t OP_REL_WR  = 4'd9;
    localparam op_t OP_EMIT    = 4'd10;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER      = 3'd0;
    localparam cond_t C_ALWAYS     = 3'd1;
    localparam cond_t C_NO_BEAT    = 3'd2;
    localparam cond_t C_OUT_BUSY   = 3'd3;
    localparam cond_t C_GATE_OFF   = 3'd4;
    localparam cond_t C_NOT_ATTACK = 3'd5;
    localparam cond_t C_LT_ONE     = 3'd6;
    localparam cond_t C_NOT_DECAY  = 3'd7;

    typedef struct packed {
        mul_sel_t mul;
        op_t      op;
        cond_t    cond;
        step_t    target;
    } ucode_t;

    function automatic ucode_t ucode_word(input step_t s);
        ucode_t w;
        w = '{mul: MUL_NONE, op: OP_NOP, cond: C_NEVER, target: S_EMIT};
        unique case (s)
            S_EMIT: w = '{mul: MUL_NONE,   op: OP_EMIT,    cond: C_OUT_BUSY,   target: S_EMIT};
            S_IDLE: w = '{mul: MUL_NONE,   op: OP_LATCH,   cond: C_NO_BEAT,    target: S_IDLE};
            S_DEB:  w = '{mul: MUL_DEB,    op: OP_NOP,     cond: C_NEVER,      target: S_EMIT};
            S_DEBW: w = '{mul: MUL_NONE,   op: OP_DEB_WR,  cond: C_GATE_OFF,   target: S_REL};
            S_ATK:  w = '{mul: MUL_ATK,    op: OP_NOP,     cond: C_NOT_ATTACK, target: S_CHK};
            S_ATKW: w = '{mul: MUL_NONE,   op: OP_ATK_WR,  cond: C_NEVER,      target: S_EMIT};
            S_CHK:  w = '{mul: MUL_LOGPOS, op: OP_NOP,     cond: C_LT_ONE,     target: S_DCHK};
            S_LOG1: w = '{mul: MUL_NONE,   op: OP_ROM_IDX, cond: C_NEVER,      target: S_EMIT};
            S_LOG2: w = '{mul: MUL_NONE,   op: OP_ROM_LO,  cond: C_NEVER,      target: S_EMIT};
            S_LOG3: w = '{mul: MUL_INTERP, op: OP_NOP,     cond: C_NEVER,      target: S_EMIT};
            S_LOG4: w = '{mul: MUL_NONE,   op: OP_LOG_WR,  cond: C_NEVER,      target: S_EMIT};
            S_DCHK: w = '{mul: MUL_TGT,    op: OP_NOP,     cond: C_NOT_DECAY,  target: S_EMIT};
            S_DEC1: w = '{mul: MUL_DEC,    op: OP_TGT,     cond: C_NEVER,      target: S_EMIT};
            S_DEC2: w = '{mul: MUL_NONE,   op: OP_DEC_WR,  cond: C_ALWAYS,     target: S_EMIT};
            S_REL:  w = '{mul: MUL_REL,    op: OP_NOP,     cond: C_NEVER,      target: S_EMIT};
            S_RELW: w = '{mul: MUL_NONE,   op: OP_REL_WR,  cond: C_ALWAYS,     target: S_EMIT};
        endcase
        return w;
    endfunction

    // shift-subtract quotient, used only while building the log table
    function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/depth) in Q0.32 through 2*atanh((m-1)/(m+1))
    function automatic logic [31:0] ln_entry(input int i, input int depth);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        z   = quot64(64'(i) << 32, 64'(2 * depth + i));
        z2  = (z * z) >> 32;
        pw  = z;
        acc = '0;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            acc = acc + quot64(pw, 64'(2 * n + 1));
            pw  = (pw * z2) >> 32;
        end
        acc = acc << 1;
        return acc[31:0];
    endfunction

endpackage

FILE: hw/rtl/dgadsr_in_if.sv
interface dgadsr_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

FILE: hw/rtl/dgadsr_out_if.sv
interface dgadsr_out_if
    import dgadsr_pkg::*;
#(
    parameter int ENV_W = ENV_W_DEF
);
    logic             valid;
    logic             ready;
    logic [ENV_W-1:0] envelope;
    logic             gate_on;
    logic [1:0]       stage_now;

    modport source (output valid, output envelope, output gate_on, output stage_now,
                    input ready);
    modport sink (input valid, input envelope, input gate_on, input stage_now,
                  output ready);
endinterface

FILE: hw/rtl/dgadsr_ln_rom.sv
module dgadsr_ln_rom
    import dgadsr_pkg::*;
#(
    parameter int DEPTH = LOG_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH + 1)
)(
    input  logic          clk,
    input  logic [AW-1:0] addr,
    output logic [31:0]   data
);

    logic [31:0] tab [0:DEPTH];

    for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
        localparam logic [31:0] VAL = ln_entry(g, DEPTH);
        assign tab[g] = VAL;
    end

    always_ff @(posedge clk)
    begin
        if (addr <= AW'(DEPTH))
        begin
            data <= tab[addr];
        end
        else
        begin
            data <= '0;
        end
    end

endmodule

FILE: hw/rtl/debounced_gate_adsr_envelope.sv
// Debounced gate ADSR envelope. Each sample beat carries one raw active-low
// button level; the block filters it, derives the gate, advances the envelope
// by one tick and returns one result beat (envelope level, gate, stage). A
// microcode sequencer steps one shared 32x32 multiplier through the tick: the
// debounce filter, then the release update when the gate is off, else the
// attack update in attack, a log step with table interpolation when the level
// reaches one, and the decay update in decay; the emit step waits while the
// output register is full. The next sample is taken while the previous result
// still waits in the output register. Configuration writes are taken at any
// time but are meant for when the block is idle.
module debounced_gate_adsr_envelope
    import dgadsr_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int LOG_TABLE_DEPTH = LOG_DEPTH_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    dgadsr_in_if.sink            sample,
    dgadsr_out_if.source         result,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int          LW      = FRAC_BITS + 2;
    localparam int          AW      = $clog2(LOG_TABLE_DEPTH + 1);
    localparam logic [63:0] LVL_ONE = 64'd1 << FRAC_BITS;
    localparam logic [63:0] LVL_MAX = (64'd1 << LW) - 64'd1;
    localparam logic [63:0] LN_RND  = 64'd1 << (31 - FRAC_BITS);

    function automatic logic [LW-1:0] sat_lvl(input logic [63:0] v);
        return (v > LVL_MAX) ? LVL_MAX[LW-1:0] : v[LW-1:0];
    endfunction

    logic [CFG_W-1:0] attack_rate_reg, attack_keep_reg, decay_rate_reg;
    logic [CFG_W-1:0] sustain_level_reg, decay_keep_reg, release_keep_reg;

    step_t         step_reg, step_next;
    ucode_t        uw;
    logic [15:0]   deb_reg, deb_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    stage_t        stage_reg, stage_next;
    logic          gate_reg, gate_next;
    logic          press_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   mul_a, mul_b;
    logic [AW-1:0] idx_reg;
    logic [FRAC_BITS-1:0] fr_reg;
    logic [31:0]   lo_reg;
    logic [63:0]   tgt_reg;
    logic [AW-1:0] rom_addr;
    logic [31:0]   rom_q;
    logic          out_valid_reg;
    logic [LW-1:0] out_env_reg;
    logic          out_gate_reg;
    stage_t        out_stage_reg;

    logic          jump;
    logic          out_free;
    logic [63:0]   rnd16;
    logic [63:0]   deb_sum;
    logic [63:0]   deb_q;
    logic [63:0]   inc;
    logic [63:0]   ln_sum;
    logic          log_k;
    logic [LW-1:0] log_m;

    assign uw       = ucode_word(step_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign rnd16    = (prod_reg + 64'd32768) >> 16;
    assign log_k    = (64'(lvl_reg) >= (LVL_ONE << 1));
    assign log_m    = log_k ? (lvl_reg >> 1) : lvl_reg;
    assign deb_sum  = (press_reg ? (DEB_IN_W << 16) : 64'd0) + prod_reg + 64'd32768;
    assign deb_q    = deb_sum >> 16;
    assign deb_next = (deb_q > 64'd65535) ? 16'hFFFF : deb_q[15:0];
    assign gate_next = deb_next > DEB_HALF;
    assign inc      = ({47'd0, attack_rate_reg, 1'b0} << FRAC_BITS) >> 16;
    assign ln_sum   = 64'(lo_reg) + (prod_reg >> FRAC_BITS) + (log_k ? LN2_Q32 : 64'd0);

    always_comb
    begin
        unique case (uw.mul)
            MUL_DEB:
            begin
                mul_a = 32'(deb_reg);
                mul_b = 32'(DEB_KEEP_W);
            end
            MUL_ATK:
            begin
                mul_a = 32'(lvl_reg);
                mul_b = 32'(attack_keep_reg);
            end
            MUL_LOGPOS:
            begin
                mul_a = 32'(log_m[FRAC_BITS-1:0]);
                mul_b = 32'(LOG_TABLE_DEPTH);
            end
            MUL_INTERP:
            begin
                mul_a = rom_q - lo_reg;
                mul_b = 32'(fr_reg);
            end
            MUL_TGT:
            begin
                mul_a = 32'(decay_rate_reg);
                mul_b = 32'(sustain_level_reg);
            end
            MUL_DEC:
            begin
                mul_a = 32'(lvl_reg);
                mul_b = 32'(decay_keep_reg);
            end
            MUL_REL:
            begin
                mul_a = 32'(lvl_reg);
                mul_b = 32'(release_keep_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_BEAT:    jump = !sample.valid;
            C_OUT_BUSY:   jump = !out_free;
            C_GATE_OFF:   jump = !gate_next;
            C_NOT_ATTACK: jump = stage_reg != STAGE_ATTACK;
            C_LT_ONE:     jump = 64'(lvl_reg) < LVL_ONE;
            C_NOT_DECAY:  jump = stage_reg != STAGE_DECAY;
        endcase
        step_next = jump ? uw.target : step_reg + 4'd1;
    end

    always_comb
    begin
        lvl_next   = lvl_reg;
        stage_next = stage_reg;
        unique case (uw.op)
            OP_DEB_WR:
            begin
                if (!gate_next)
                begin
                    stage_next = STAGE_RELEASE;
                end
                else if (stage_reg == STAGE_RELEASE)
                begin
                    stage_next = STAGE_ATTACK;
                end
            end
            OP_ATK_WR: lvl_next   = sat_lvl(inc + rnd16);
            OP_ROM_IDX: stage_next = STAGE_DECAY;
            OP_LOG_WR: lvl_next   = sat_lvl(((ln_sum + LN_RND) >> (32 - FRAC_BITS)) + LVL_ONE);
            OP_DEC_WR: lvl_next   = sat_lvl(tgt_reg + rnd16);
            OP_REL_WR: lvl_next   = sat_lvl(rnd16);
            default:
            begin
                lvl_next   = lvl_reg;
                stage_next = stage_reg;
            end
        endcase
    end

    assign rom_addr = (uw.op == OP_ROM_IDX) ? prod_reg[FRAC_BITS +: AW] : idx_reg + AW'(1);

    dgadsr_ln_rom #(
        .DEPTH (LOG_TABLE_DEPTH)
    ) u_ln_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_rate_reg   <= ATTACK_RATE_RST;
            attack_keep_reg   <= ATTACK_KEEP_RST;
            decay_rate_reg    <= DECAY_RATE_RST;
            sustain_level_reg <= SUSTAIN_LEVEL_RST;
            decay_keep_reg    <= DECAY_KEEP_RST;
            release_keep_reg  <= RELEASE_KEEP_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ATTACK_RATE:   attack_rate_reg   <= cfg_data;
                REG_ATTACK_KEEP:   attack_keep_reg   <= cfg_data;
                REG_DECAY_RATE:    decay_rate_reg    <= cfg_data;
                REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data;
                REG_DECAY_KEEP:    decay_keep_reg    <= cfg_data;
                REG_RELEASE_KEEP:  release_keep_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            deb_reg       <= '0;
            lvl_reg       <= '0;
            stage_reg     <= STAGE_RELEASE;
            gate_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            lvl_reg   <= lvl_next;
            stage_reg <= stage_next;
            if (uw.op == OP_DEB_WR)
            begin
                deb_reg  <= deb_next;
                gate_reg <= gate_next;
            end
            if (uw.op == OP_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.mul != MUL_NONE)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (uw.op == OP_LATCH && sample.valid)
        begin
            press_reg <= !sample.button_level;
        end
        if (uw.op == OP_ROM_IDX)
        begin
            idx_reg <= prod_reg[FRAC_BITS +: AW];
            fr_reg  <= prod_reg[FRAC_BITS-1:0];
        end
        if (uw.op == OP_ROM_LO)
        begin
            lo_reg <= rom_q;
        end
        if (uw.op == OP_TGT)
        begin
            tgt_reg <= ((prod_reg[31:0] << FRAC_BITS) + 64'h8000_0000) >> 32;
        end
        if (uw.op == OP_EMIT && out_free)
        begin
            out_env_reg   <= lvl_reg;
            out_gate_reg  <= gate_reg;
            out_stage_reg <= stage_reg;
        end
    end

    assign sample.ready     = (step_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.envelope  = out_env_reg;
    assign result.gate_on   = out_gate_reg;
    assign result.stage_now = out_stage_reg;

    a_beat_starts_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> step_reg == S_DEB)
        else $error("sample beat did not start a tick");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(step_reg == S_EMIT))
        else $error("result beat raised outside the emit step");

    a_gate_off_release: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_EMIT && !gate_reg) |-> stage_reg == STAGE_RELEASE)
        else $error("gate off but stage is not release");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dgadsr_pkg::*;

    localparam int ENV_W      = ENV_W_DEF;
    localparam int ROM_DEPTH  = LOG_DEPTH_DEF;
    localparam int WATCHDOG   = 5000;
    localparam int HOLDOFF    = 300;
    localparam int SETTLE     = 40;
    localparam int PHASE_LEN  = 135;
    localparam logic [63:0] LVL_ONE = 64'd1 << FRAC_BITS_DEF;
    localparam logic [63:0] LVL_MAX = (64'd1 << (FRAC_BITS_DEF + 2)) - 64'd1;

    typedef struct packed {
        logic btn;
        logic hold;
    } tick_t;

    typedef struct packed {
        logic [ENV_W-1:0] envelope;
        logic             gate_on;
        stage_t           stage;
    } env_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    dgadsr_in_if sample_if();
    dgadsr_out_if #(.ENV_W(ENV_W)) result_if();

    debounced_gate_adsr_envelope dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tick_t     tick_q[$];
    env_beat_t env_expect_q[$];

    logic [63:0] ln_rom [0:ROM_DEPTH];
    logic [CFG_W-1:0] reg_q [0:5];
    logic [15:0] deb_q;
    logic [ENV_W-1:0] env_q;
    stage_t stage_q;

    int send_idle_pct;
    int recv_idle_pct;
    int holdoff_ask;
    int holdoff_seen;
    int holdoff_left;
    int quiet_cycles;
    int mismatches;
    env_beat_t want_beat;
    env_beat_t got_beat;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.button_level = 1'b1;
        result_if.ready = 1'b0;
    end

    initial
    begin
        logic [63:0] z, z2, pw, acc;
        for (int i = 0; i <= ROM_DEPTH; i++)
        begin
            z = (64'(i) << 32) / (64'(2 * ROM_DEPTH + i));
            z2 = (z * z) >> 32;
            pw = z;
            acc = '0;
            for (int n = 0; n < SERIES_TERMS; n++)
            begin
                acc = acc + pw / 64'(2 * n + 1);
                pw = (pw * z2) >> 32;
            end
            ln_rom[i] = {32'd0, acc[30:0], 1'b0};
        end
    end

    function automatic logic [63:0] clamp_level(input logic [63:0] v);
        return (v > LVL_MAX) ? LVL_MAX : v;
    endfunction

    function automatic logic [63:0] scale_q16(input logic [63:0] lvl, input logic [CFG_W-1:0] k);
        return (lvl * 64'(k) + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] log_plus_one(input logic [63:0] lvl);
        logic [63:0] k, mfrac, pos, idx, fr, lo, hi, ln;
        k = (lvl >= (LVL_ONE << 1)) ? 64'd1 : 64'd0;
        mfrac = ((lvl >> k) - LVL_ONE) & (LVL_ONE - 64'd1);
        pos = mfrac * 64'(ROM_DEPTH);
        idx = pos >> FRAC_BITS_DEF;
        fr = pos & (LVL_ONE - 64'd1);
        if (idx >= 64'(ROM_DEPTH))
            idx = 64'(ROM_DEPTH - 1);
        lo = ln_rom[idx];
        hi = ln_rom[idx + 1];
        ln = lo + (((hi - lo) * fr) >> FRAC_BITS_DEF);
        ln = ln + k * LN2_Q32;
        ln = (ln + (64'd1 << (31 - FRAC_BITS_DEF))) >> (32 - FRAC_BITS_DEF);
        return clamp_level(ln + LVL_ONE);
    endfunction

    function automatic env_beat_t advance_envelope(input logic btn);
        logic [63:0] d, lvl, tgt;
        logic gate;
        env_beat_t r;
        d = (DEB_IN_W * (btn ? 64'd0 : 64'd1) * 64'd65536 + 64'(DEB_KEEP_W) * 64'(deb_q)
             + 64'd32768) >> 16;
        if (d > 64'hFFFF)
            d = 64'hFFFF;
        deb_q = d[15:0];
        gate = d > 64'(DEB_HALF);
        lvl = 64'(env_q);
        if (gate)
        begin
            if (stage_q == STAGE_RELEASE)
                stage_q = STAGE_ATTACK;
            if (stage_q == STAGE_ATTACK)
                lvl = clamp_level(64'(reg_q[REG_ATTACK_RATE]) * 64'd2
                                  + scale_q16(lvl, reg_q[REG_ATTACK_KEEP]));
            if (lvl >= LVL_ONE)
            begin
                stage_q = STAGE_DECAY;
                lvl = log_plus_one(lvl);
            end
            if (stage_q == STAGE_DECAY)
            begin
                tgt = (((64'(reg_q[REG_DECAY_RATE]) * 64'(reg_q[REG_SUSTAIN_LEVEL]))
                        << FRAC_BITS_DEF) + 64'd2147483648) >> 32;
                lvl = clamp_level(tgt + scale_q16(lvl, reg_q[REG_DECAY_KEEP]));
            end
        end
        else
        begin
            stage_q = STAGE_RELEASE;
            lvl = clamp_level(scale_q16(lvl, reg_q[REG_RELEASE_KEEP]));
        end
        env_q = lvl[ENV_W-1:0];
        r.envelope = env_q;
        r.gate_on = gate;
        r.stage = stage_q;
        return r;
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
            sample_if.button_level <= 1'b1;
        end
        else
        begin
            if (sample_if.valid && sample_if.ready)
                env_expect_q.push_back(advance_envelope(sample_if.button_level));
            if (!sample_if.valid || sample_if.ready)
            begin
                if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(tick_q[0].hold && env_expect_q.size() != 0))
                begin
                    sample_if.valid <= 1'b1;
                    sample_if.button_level <= tick_q[0].btn;
                    void'(tick_q.pop_front());
                end
                else
                    sample_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            holdoff_seen <= 0;
            holdoff_left <= 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got_beat.envelope = result_if.envelope;
                got_beat.gate_on = result_if.gate_on;
                got_beat.stage = result_if.stage_now;
                if (env_expect_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected beat: env %0d gate %0d stage %0d",
                                 got_beat.envelope, got_beat.gate_on, got_beat.stage);
                end
                else
                begin
                    want_beat = env_expect_q.pop_front();
                    if (got_beat.envelope !== want_beat.envelope
                        || got_beat.gate_on !== want_beat.gate_on
                        || got_beat.stage !== want_beat.stage)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"beat differs: expected env %0d gate %0d stage %0d, ",
                                      "got env %0d gate %0d stage %0d"},
                                     want_beat.envelope, want_beat.gate_on, want_beat.stage,
                                     got_beat.envelope, got_beat.gate_on, got_beat.stage);
                    end
                end
            end
            if (holdoff_left > 0)
            begin
                holdoff_left <= holdoff_left - 1;
                result_if.ready <= 1'b0;
            end
            else if (holdoff_ask != holdoff_seen)
            begin
                holdoff_seen <= holdoff_ask;
                holdoff_left <= HOLDOFF;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG);
        $display("debounced_gate_adsr_envelope: mismatch");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        reg_q[idx] = val;
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] a_rate, input logic [CFG_W-1:0] a_keep,
                                 input logic [CFG_W-1:0] d_rate, input logic [CFG_W-1:0] sus,
                                 input logic [CFG_W-1:0] d_keep, input logic [CFG_W-1:0] r_keep);
        write_reg(REG_ATTACK_RATE, a_rate);
        write_reg(REG_ATTACK_KEEP, a_keep);
        write_reg(REG_DECAY_RATE, d_rate);
        write_reg(REG_SUSTAIN_LEVEL, sus);
        write_reg(REG_DECAY_KEEP, d_keep);
        write_reg(REG_RELEASE_KEEP, r_keep);
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic push_run(input logic btn, input int len);
        for (int i = 0; i < len; i++)
            tick_q.push_back('{btn: btn, hold: 1'b0});
    endtask

    task automatic fill_ticks(input int target);
        int n, len, kind;
        n = 0;
        while (n < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                len = $urandom_range(75, 160);
                if (len > target - n)
                    len = target - n;
                push_run(1'b0, len);
                n = n + len;
                len = $urandom_range(20, 90);
                if (len > target - n)
                    len = target - n;
                push_run(1'b1, len);
                n = n + len;
            end
            else if (kind < 9)
            begin
                len = $urandom_range(5, 30);
                if (len > target - n)
                    len = target - n;
                for (int i = 0; i < len; i++)
                    tick_q.push_back('{btn: 1'($urandom_range(0, 1)), hold: 1'b0});
                n = n + len;
            end
            else
            begin
                len = $urandom_range(10, 50);
                if (len > target - n)
                    len = target - n;
                push_run(1'b0, len);
                n = n + len;
                len = $urandom_range(5, 20);
                if (len > target - n)
                    len = target - n;
                push_run(1'b1, len);
                n = n + len;
            end
        end
    endtask

    task automatic drain;
        while (tick_q.size() != 0 || env_expect_q.size() != 0 || sample_if.valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [1:0] directed [20];
        directed = '{1, 1, 0, 0, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0, 1};
        mismatches = 0;
        quiet_cycles = 0;
        holdoff_ask = 0;
        send_idle_pct = 20;
        recv_idle_pct = 48;
        reg_q[REG_ATTACK_RATE] = ATTACK_RATE_RST;
        reg_q[REG_ATTACK_KEEP] = ATTACK_KEEP_RST;
        reg_q[REG_DECAY_RATE] = DECAY_RATE_RST;
        reg_q[REG_SUSTAIN_LEVEL] = SUSTAIN_LEVEL_RST;
        reg_q[REG_DECAY_KEEP] = DECAY_KEEP_RST;
        reg_q[REG_RELEASE_KEEP] = RELEASE_KEEP_RST;
        deb_q = '0;
        env_q = '0;
        stage_q = STAGE_RELEASE;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 20; i++)
            tick_q.push_back('{btn: directed[i][0], hold: 1'b0});
        drain();

        for (int ph = 1; ph <= 8; ph++)
        begin
            @(posedge clk);
            if (ph == 3)
            begin
                send_idle_pct <= 48;
                recv_idle_pct <= 20;
            end
            else if (ph == 6)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case (ph)
                1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                3: apply_setting(16'd3000, 16'd60000, 16'd20000, 16'd40000, 16'd50000,
                                 16'd60000);
                5: apply_setting(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
                7: apply_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd1);
                default: apply_setting(16'($urandom_range(300, 20000)),
                                       16'($urandom_range(50000, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)));
            endcase
            @(negedge clk);
            if (ph == 4)
            begin
                fill_ticks(PHASE_LEN / 2);
                tick_q.push_back('{btn: 1'($urandom_range(0, 1)), hold: 1'b1});
                fill_ticks(PHASE_LEN / 2);
            end
            else
                fill_ticks(PHASE_LEN);
            if (ph == 1)
                holdoff_ask = holdoff_ask + 1;
            drain();
        end

        if (mismatches == 0)
            $display("debounced_gate_adsr_envelope: match");
        else
            $display("debounced_gate_adsr_envelope: mismatch");
        $finish;
    end

endmodule
